// ----- design/slj_pkg.sv -----
// Shared types, constants and step functions of the slider joint datapath.
// Depends on nothing; every other file imports it.
package slj_pkg;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int UB = 30;
    localparam int RW = 31;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS = 31;

    typedef struct packed {
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_z;
        logic signed [CW-1:0] line_point_x;
        logic signed [CW-1:0] line_point_y;
        logic signed [CW-1:0] line_point_z;
        logic signed [CW-1:0] direction_x;
        logic signed [CW-1:0] direction_y;
        logic signed [CW-1:0] direction_z;
        logic [RW-1:0]        rod_length;
    } joint_query_t;

    typedef struct packed {
        logic signed [CW-1:0] joint_x;
        logic signed [CW-1:0] joint_y;
        logic signed [CW-1:0] joint_z;
        logic                 no_intersection;
        logic                 degenerate;
    } joint_result_t;

    typedef logic [2:0][CW-1:0] word3_t;
    typedef logic [2:0][UB:0]   unit3_t;

    typedef struct packed {
        word3_t        p;
        word3_t        dm;
        logic [2:0]    dneg;
        logic [2:0]    eneg;
        logic [RW-1:0] rod;
        logic          degen;
    } ctx_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [CW-1:0] rem;
        logic [UB:0]   quo;
    } div_t;

    function automatic sqrt_t sqrt_step(input sqrt_t s, input int unsigned j);
        logic [63:0] bitv;
        logic [63:0] trial;
        sqrt_t       r;
        bitv = 64'd1 << (62 - 2 * j);
        trial = s.root + bitv;
        if (s.rem >= trial)
        begin
            r.rem = s.rem - trial;
            r.root = (s.root >> 1) + bitv;
        end
        else
        begin
            r.rem = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

    function automatic div_t div_step(input div_t s, input logic [CW-1:0] n);
        logic [CW:0] t;
        logic        q;
        div_t        r;
        t = {s.rem, s.quo[UB]};
        q = (t >= {1'b0, n});
        if (q)
            r.rem = CW'(t - {1'b0, n});
        else
            r.rem = t[CW-1:0];
        r.quo = {s.quo[UB-1:0], q};
        return r;
    endfunction

endpackage

// ----- design/slider_joint_position.sv -----
// Top level of the slider joint solver: line/sphere intersection pipeline.
// Depends on slj_pkg for the transfer structs, step functions and constants.

// One query enters per clock while the result side takes results; the
// datapath holds two 32-stage square-root pipelines and a 31-stage
// divider per axis, one result bit per stage. A stall on the result side holds the
// whole pipeline, so throughput is one transfer per cycle while the result
// side takes them. Outputs are saturated Q16.16; degenerate marks a zero
// direction (joint equals the line point), no_intersection marks a miss
// (joint is the foot of the perpendicular from the center).
module slider_joint_position
    import slj_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  joint_query_t  query,
    input  logic          query_valid,
    output logic          query_stall,
    output joint_result_t result,
    output logic          result_valid,
    input  logic          result_stall
);

    localparam int S_SQ1 = 4;
    localparam int S_DIV = S_SQ1 + SQRT_STEPS + 1;
    localparam int S_G   = S_DIV + DIV_STEPS + 1;
    localparam int S_SQ2 = S_G + 4;
    localparam int S_L   = S_SQ2 + SQRT_STEPS + 1;
    localparam int LAST  = S_L + 3;

    logic adv;
    logic vld_reg [0:LAST];
    logic result_valid_reg;
    joint_result_t result_reg;
    joint_result_t result_next;

    joint_query_t a_reg;
    ctx_t ctx_reg [1:LAST];
    ctx_t ctx_next;
    word3_t em_raw_reg, em_raw_next;
    logic [CW-1:0] emax_reg, emax_next;
    word3_t em_reg [2:S_DIV-1];
    word3_t em_next;
    logic [2:0][63:0] sq_reg;
    sqrt_t s1_reg [S_SQ1:S_DIV-1];
    logic [CW-1:0] n_reg [S_DIV:S_G-2];
    div_t dv_reg [S_DIV:S_G-1][0:2];
    div_t dv_next [0:2];
    unit3_t um_reg [S_G:LAST-2];
    logic [2:0][62:0] pf_reg;
    logic [2:0][63:0] dsqr_reg;
    logic [61:0] rsqr_reg;
    logic signed [36:0] f1_reg [S_G+1:S_L-1];
    logic signed [36:0] f1_next;
    logic [49:0] dsq_reg [S_G+1:S_G+3];
    logic [49:0] dsq_next;
    logic [45:0] rsq_reg [S_G+1:S_G+3];
    logic [45:0] rsq_next;
    logic [39:0] hh_reg;
    logic [35:0] hl_reg;
    logic [31:0] ll_reg;
    logic [35:0] mf;
    logic [57:0] f1sq_reg;
    logic [1:0] mb_reg [S_SQ2:LAST];
    sqrt_t s2_reg [S_SQ2:S_L-1];
    sqrt_t s2_next;
    logic miss_next;
    logic bigq_next;
    logic signed [41:0] x1_reg, x2_reg;
    logic [40:0] f2;
    logic [40:0] mx_reg, mx_next;
    logic xneg_reg [LAST-2:LAST];
    logic xneg_next;
    logic [2:0][46:0] pl_reg;
    logic [2:0][55:0] ph_reg;
    logic [2:0][41:0] tm_reg;
    logic [2:0][41:0] tm_next;

    assign adv = !result_valid_reg || !result_stall;
    assign query_stall = !adv;
    assign result = result_reg;
    assign result_valid = result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= LAST; s++)
                vld_reg[s] <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= query_valid;
            for (int s = 0; s < LAST; s++)
                vld_reg[s+1] <= vld_reg[s];
            result_valid_reg <= vld_reg[LAST];
        end
    end

    // Difference vector, direction magnitudes and largest magnitude
    always_comb
    begin
        logic signed [CW-1:0] cv [0:2];
        logic signed [CW-1:0] pv [0:2];
        logic signed [CW-1:0] ev [0:2];
        logic signed [CW:0]   dd;
        cv[0] = a_reg.center_x;
        cv[1] = a_reg.center_y;
        cv[2] = a_reg.center_z;
        pv[0] = a_reg.line_point_x;
        pv[1] = a_reg.line_point_y;
        pv[2] = a_reg.line_point_z;
        ev[0] = a_reg.direction_x;
        ev[1] = a_reg.direction_y;
        ev[2] = a_reg.direction_z;
        emax_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            dd = (CW+1)'(cv[i]) - (CW+1)'(pv[i]);
            ctx_next.p[i] = pv[i];
            ctx_next.dneg[i] = dd[CW];
            ctx_next.dm[i] = dd[CW] ? CW'(-dd) : dd[CW-1:0];
            ctx_next.eneg[i] = ev[i][CW-1];
            em_raw_next[i] = ev[i][CW-1] ? CW'(-ev[i]) : ev[i];
            if (em_raw_next[i] > emax_next)
                emax_next = em_raw_next[i];
        end
        ctx_next.rod = a_reg.rod_length;
        ctx_next.degen = (emax_next == '0);
    end

    // Normalize the direction so that its largest magnitude reaches 2^30
    always_comb
    begin
        logic [4:0] k;
        k = '0;
        for (int b = 0; b < UB + 1; b++)
            if (emax_reg[b])
                k = 5'(UB - b);
        if (emax_reg[CW-1])
            k = '0;
        for (int i = 0; i < 3; i++)
            em_next[i] = em_raw_reg[i] << k;
    end

    always_comb
    begin
        logic [61:0] num;
        for (int i = 0; i < 3; i++)
        begin
            num = {em_reg[S_DIV-1][i], {UB{1'b0}}} + 62'(s1_reg[S_DIV-1].root[CW-1:1]);
            dv_next[i].rem = CW'(num[61:UB+1]);
            dv_next[i].quo = num[UB:0];
        end
    end

    // Dot product terms, squared lengths, rod squared
    always_comb
    begin
        logic [63:0] rt;
        logic [64:0] dq;
        logic [62:0] rr;
        f1_next = '0;
        dsq_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            rt = (64'(pf_reg[i]) + 64'(1 << (UB - 1))) >> UB;
            if (ctx_reg[S_G].dneg[i] ^ ctx_reg[S_G].eneg[i])
                f1_next = f1_next - 37'(rt);
            else
                f1_next = f1_next + 37'(rt);
            dq = (65'(dsqr_reg[i]) + 65'(1 << (FB - 1))) >> FB;
            dsq_next = dsq_next + 50'(dq);
        end
        rr = (63'(rsqr_reg) + 63'(1 << (FB - 1))) >> FB;
        rsq_next = 46'(rr);
    end

    assign mf = f1_reg[S_G+1][36] ? 36'(-f1_reg[S_G+1]) : 36'(f1_reg[S_G+1]);

    // Discriminant, clamp, and operand scaling for the second root
    always_comb
    begin
        logic signed [59:0] q;
        logic [57:0] qc;
        q = 60'(rsq_reg[S_G+3]) + 60'(f1sq_reg) - 60'(dsq_reg[S_G+3]);
        miss_next = q[59];
        qc = miss_next ? '0 : q[57:0];
        bigq_next = (qc >= 58'(64'd1 << 48));
        s2_next.root = '0;
        s2_next.rem = bigq_next ? 64'(qc) : 64'(qc) << FB;
    end

    assign f2 = mb_reg[S_L-1][0] ? (41'(s2_reg[S_L-1].root[32:0]) << (FB / 2))
                                 : 41'(s2_reg[S_L-1].root[32:0]);

    always_comb
    begin
        logic [41:0] m1;
        logic [41:0] m2;
        logic signed [41:0] x;
        m1 = x1_reg[41] ? 42'(-x1_reg) : 42'(x1_reg);
        m2 = x2_reg[41] ? 42'(-x2_reg) : 42'(x2_reg);
        x = (m1 < m2) ? x1_reg : x2_reg;
        xneg_next = x[41];
        mx_next = x[41] ? 41'(-x) : 41'(x);
    end

    always_comb
    begin
        logic [72:0] prod;
        for (int i = 0; i < 3; i++)
        begin
            prod = (73'(ph_reg[i]) << 16) + 73'(pl_reg[i]) + 73'(1 << (UB - 1));
            tm_next[i] = 42'(prod >> UB);
        end
    end

    // Apply the signed offset along the unit vector and saturate; degenerate takes the line point
    always_comb
    begin
        logic signed [44:0] t;
        logic signed [44:0] s;
        logic signed [CW-1:0] j [0:2];
        for (int i = 0; i < 3; i++)
        begin
            t = (xneg_reg[LAST] ^ ctx_reg[LAST].eneg[i]) ? -45'(tm_reg[i]) : 45'(tm_reg[i]);
            s = 45'($signed(ctx_reg[LAST].p[i])) + t;
            if (s > 45'sd2147483647)
                j[i] = {1'b0, {(CW-1){1'b1}}};
            else if (s < -45'sd2147483648)
                j[i] = {1'b1, {(CW-1){1'b0}}};
            else
                j[i] = s[CW-1:0];
            if (ctx_reg[LAST].degen)
                j[i] = ctx_reg[LAST].p[i];
        end
        result_next.joint_x = j[0];
        result_next.joint_y = j[1];
        result_next.joint_z = j[2];
        result_next.no_intersection = !ctx_reg[LAST].degen && mb_reg[LAST][1];
        result_next.degenerate = ctx_reg[LAST].degen;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= query;
            ctx_reg[1] <= ctx_next;
            for (int s = 1; s < LAST; s++)
                ctx_reg[s+1] <= ctx_reg[s];
            em_raw_reg <= em_raw_next;
            emax_reg <= emax_next;
            em_reg[2] <= em_next;
            for (int s = 2; s < S_DIV - 1; s++)
                em_reg[s+1] <= em_reg[s];
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= 64'(em_reg[2][i]) * 64'(em_reg[2][i]);
            s1_reg[S_SQ1].rem <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            s1_reg[S_SQ1].root <= '0;
            n_reg[S_DIV] <= s1_reg[S_DIV-1].root[CW-1:0];
            for (int s = S_DIV; s < S_G - 2; s++)
                n_reg[s+1] <= n_reg[s];
            for (int i = 0; i < 3; i++)
            begin
                dv_reg[S_DIV][i] <= dv_next[i];
                um_reg[S_G][i] <= dv_reg[S_G-1][i].quo;
                pf_reg[i] <= 63'(ctx_reg[S_G-1].dm[i]) * 63'(dv_reg[S_G-1][i].quo);
                dsqr_reg[i] <= 64'(ctx_reg[S_G-1].dm[i]) * 64'(ctx_reg[S_G-1].dm[i]);
            end
            rsqr_reg <= 62'(ctx_reg[S_G-1].rod) * 62'(ctx_reg[S_G-1].rod);
            for (int s = S_G; s < LAST - 2; s++)
                um_reg[s+1] <= um_reg[s];
            f1_reg[S_G+1] <= f1_next;
            for (int s = S_G + 1; s < S_L - 1; s++)
                f1_reg[s+1] <= f1_reg[s];
            dsq_reg[S_G+1] <= dsq_next;
            rsq_reg[S_G+1] <= rsq_next;
            for (int s = S_G + 1; s < S_G + 3; s++)
            begin
                dsq_reg[s+1] <= dsq_reg[s];
                rsq_reg[s+1] <= rsq_reg[s];
            end
            hh_reg <= 40'(mf[35:16]) * 40'(mf[35:16]);
            hl_reg <= 36'(mf[35:16]) * 36'(mf[15:0]);
            ll_reg <= 32'(mf[15:0]) * 32'(mf[15:0]);
            f1sq_reg <= (58'(hh_reg) << FB) + (58'(hl_reg) << 1)
                      + 58'((33'(ll_reg) + 33'(1 << (FB - 1))) >> FB);
            s2_reg[S_SQ2] <= s2_next;
            mb_reg[S_SQ2] <= {miss_next, bigq_next};
            for (int s = S_SQ2; s < LAST; s++)
                mb_reg[s+1] <= mb_reg[s];
            x1_reg <= 42'(f1_reg[S_L-1]) + 42'(f2);
            x2_reg <= 42'(f1_reg[S_L-1]) - 42'(f2);
            mx_reg <= mx_next;
            xneg_reg[LAST-2] <= xneg_next;
            for (int s = LAST - 2; s < LAST; s++)
                xneg_reg[s+1] <= xneg_reg[s];
            for (int i = 0; i < 3; i++)
            begin
                pl_reg[i] <= 47'(mx_reg[15:0]) * 47'(um_reg[LAST-2][i]);
                ph_reg[i] <= 56'(mx_reg[40:16]) * 56'(um_reg[LAST-2][i]);
            end
            tm_reg <= tm_next;
            result_reg <= result_next;
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s1_reg[S_SQ1+j+1] <= sqrt_step(s1_reg[S_SQ1+j], j);
                s2_reg[S_SQ2+j+1] <= sqrt_step(s2_reg[S_SQ2+j], j);
            end
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (adv)
                    dv_reg[S_DIV+j+1][i] <= div_step(dv_reg[S_DIV+j][i], n_reg[S_DIV+j]);
            end
        end
    end

endmodule

// ----- design/slj_checker.sv -----
// Port-level checker for the slider joint solver, bound to the top level.
// Depends on slj_pkg for the transfer structs.
module slj_port_checker
    import slj_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input joint_query_t  query,
    input logic          query_valid,
    input logic          query_stall,
    input joint_result_t result,
    input logic          result_valid,
    input logic          result_stall
);

    a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        query_stall |-> (result_valid && result_stall))
        else $error("query stalled without result backpressure");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.degenerate && result.no_intersection))
        else $error("degenerate and no_intersection both set");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(result))
        else $error("result changed while stalled");

endmodule

bind slider_joint_position slj_port_checker u_slj_checker (.*);
